[design/lssc_pkg.sv]
`default_nettype none

package lssc_pkg;

  localparam logic [1:0] CMD_STEP    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [2:0] REG_TOP_SPEED  = 3'd0;
  localparam logic [2:0] REG_GAIN_P     = 3'd1;
  localparam logic [2:0] REG_GAIN_D     = 3'd2;
  localparam logic [2:0] REG_ACCEL_STEP = 3'd3;
  localparam logic [2:0] REG_DECEL_STEP = 3'd4;
  localparam logic [2:0] REG_MAP_LENGTH = 3'd5;

  localparam logic [7:0]  TOP_SPEED_RST  = 8'd255;
  localparam logic [15:0] GAIN_P_RST     = 16'd256;
  localparam logic [15:0] GAIN_D_RST     = 16'd0;
  localparam logic [11:0] ACCEL_STEP_RST = 12'd102;
  localparam logic [11:0] DECEL_STEP_RST = 12'd896;
  localparam logic [8:0]  MAP_LENGTH_RST = 9'd0;
  localparam logic [15:0] SPEED_RST      = 16'd17920;

  localparam logic [2:0] HAZ_HIGH = 3'd4;
  localparam logic [2:0] HAZ_LOW  = 3'd1;

  localparam logic [7:0] SPD_NEAR_HIGH = 8'd60;
  localparam logic [7:0] SPD_NEAR_LOW  = 8'd90;
  localparam logic [7:0] SPD_FAR_HIGH  = 8'd110;
  localparam logic [7:0] SPD_FAR_LOW   = 8'd120;
  localparam logic [7:0] SPD_CAP_WIDE  = 8'd50;
  localparam logic [7:0] SPD_CAP_MID   = 8'd70;
  localparam logic [7:0] SPD_CAP_SLIM  = 8'd90;

  localparam logic [11:0] ERR_WIDE = 12'd560;
  localparam logic [11:0] ERR_MID  = 12'd352;
  localparam logic [11:0] ERR_SLIM = 12'd240;

  localparam logic [7:0] PWM_FLOOR   = 8'd50;
  localparam logic [7:0] BRANCH_BIAS = 8'd30;

  localparam logic [1:0] BR_NONE     = 2'd0;
  localparam logic [1:0] BR_RIGHT    = 2'd1;
  localparam logic [1:0] BR_LEFT     = 2'd2;
  localparam logic [1:0] BR_STRAIGHT = 2'd3;

  typedef struct packed {
    logic [1:0] branch;
    logic       is_node;
    logic [2:0] hazard;
  } entry_t;

endpackage

`default_nettype wire

[design/lookahead_speed_steering_control.sv]
// Lookahead speed and steering controller for a two-wheel line follower. Each
// input beat carries a command: a table write (stored at once, no result), a
// restart (speed and previous error back to reset, no result), or a control
// step, which yields one result beat with both wheel PWMs and the branch
// override flag. A control step reads the track table one entry per cycle over
// map_position..map_position+LOOKAHEAD through the single table read port,
// then runs speed ramp, two passes of one shared 17x12 multiplier for the PD
// term, and steering, and registers the result; in_stall is high after the
// accept until the result is registered, and longer while the previous result
// still waits on the output when the new one is ready. The next beat can be
// accepted in the cycle after the result is registered, so control steps never
// overlap. Writes and restart complete at accept and leave the block idle; any
// other command is accepted and ignored. Configuration registers sit at byte
// address 4*i on the APB port and may be written only while the block is idle.
`default_nettype none

module lookahead_speed_steering_control #(
  parameter int TABLE_DEPTH = 256,
  parameter int LOOKAHEAD   = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_cmd,
  input  wire logic signed [10:0] in_line_position,
  input  wire logic               in_line_detected,
  input  wire logic [7:0]         in_map_position,
  input  wire logic [2:0]         in_entry_hazard,
  input  wire logic               in_entry_is_node,
  input  wire logic [1:0]         in_entry_branch,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_left_pwm,
  output logic [7:0]              out_right_pwm,
  output logic                    out_branch_override,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import lssc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = (AW > 9 ? AW : 9) + 1;
  localparam int CW = $clog2(LOOKAHEAD + 1);
  localparam logic [IW-1:0] DEPTH_I   = IW'(TABLE_DEPTH);
  localparam logic [CW-1:0] LAST_I    = CW'(LOOKAHEAD);
  localparam logic [CW-1:0] NEAR_LAST = CW'(2);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_SPEED = 3'd3;
  localparam logic [2:0] S_MUL_P = 3'd4;
  localparam logic [2:0] S_MUL_D = 3'd5;
  localparam logic [2:0] S_STEER = 3'd6;

  function automatic logic [7:0] clamp_pwm(input logic signed [19:0] v,
                                           input logic [7:0] lo,
                                           input logic [7:0] hi);
    logic [7:0] res;
    if (v < $signed({12'd0, lo})) begin
      res = lo;
    end else if (v > $signed({12'd0, hi})) begin
      res = hi;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  // configuration
  logic [7:0]  top_speed_r;
  logic [15:0] gain_p_r;
  logic [15:0] gain_d_r;
  logic [11:0] accel_r;
  logic [11:0] decel_r;
  logic [8:0]  map_len_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_speed_r <= TOP_SPEED_RST;
      gain_p_r    <= GAIN_P_RST;
      gain_d_r    <= GAIN_D_RST;
      accel_r     <= ACCEL_STEP_RST;
      decel_r     <= DECEL_STEP_RST;
      map_len_r   <= MAP_LENGTH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_TOP_SPEED:  top_speed_r <= pwdata[7:0];
        REG_GAIN_P:     gain_p_r    <= pwdata[15:0];
        REG_GAIN_D:     gain_d_r    <= pwdata[15:0];
        REG_ACCEL_STEP: accel_r     <= pwdata[11:0];
        REG_DECEL_STEP: decel_r     <= pwdata[11:0];
        REG_MAP_LENGTH: map_len_r   <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_TOP_SPEED:  prdata = {24'd0, top_speed_r};
      REG_GAIN_P:     prdata = {16'd0, gain_p_r};
      REG_GAIN_D:     prdata = {16'd0, gain_d_r};
      REG_ACCEL_STEP: prdata = {20'd0, accel_r};
      REG_DECEL_STEP: prdata = {20'd0, decel_r};
      REG_MAP_LENGTH: prdata = {23'd0, map_len_r};
      default:        prdata = 32'd0;
    endcase
  end

  logic [IW-1:0] len_i;
  assign len_i = (IW'(map_len_r) > DEPTH_I) ? DEPTH_I : IW'(map_len_r);

  // sequencer and input capture
  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  logic [CW-1:0]      cnt_r;
  logic signed [10:0] err_r;
  logic               seen_r;
  logic [7:0]         pos_r;
  logic               in_acc;
  logic               out_load;
  logic               out_valid_r;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_STEER) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_cmd == CMD_STEP) state_nxt = S_SCAN;
      S_SCAN:  if (cnt_r == LAST_I) state_nxt = S_WAIT;
      S_WAIT:  state_nxt = S_SPEED;
      S_SPEED: state_nxt = S_MUL_P;
      S_MUL_P: state_nxt = S_MUL_D;
      S_MUL_D: state_nxt = S_STEER;
      S_STEER: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SCAN) begin
        cnt_r <= cnt_r + CW'(1);
      end else begin
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      err_r  <= in_line_position;
      seen_r <= in_line_detected;
      pos_r  <= in_map_position;
    end
  end

  // track table
  entry_t        mem [TABLE_DEPTH];
  entry_t        rd_data_r;
  entry_t        wr_entry;
  logic [IW-1:0] wr_pos;
  logic [IW-1:0] idx;

  assign wr_entry = '{branch: in_entry_branch, is_node: in_entry_is_node,
                      hazard: in_entry_hazard};
  assign wr_pos   = IW'(in_map_position);
  assign idx      = IW'(pos_r) + IW'(cnt_r);

  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_WRITE && wr_pos < DEPTH_I) begin
      mem[wr_pos[AW-1:0]] <= wr_entry;
    end
    rd_data_r <= mem[idx[AW-1:0]];
  end

  // hazard scan, working on the registered read data
  logic       rd_pend_r;
  logic       rd_near_r;
  logic       rd_first_r;
  logic [2:0] near_r;
  logic [2:0] far_r;
  logic       node_hit_r;
  logic [1:0] branch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= (state_r == S_SCAN) && (idx < len_i);
    end
    rd_near_r  <= (cnt_r <= NEAR_LAST);
    rd_first_r <= (cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      near_r     <= '0;
      far_r      <= '0;
      node_hit_r <= 1'b0;
      branch_r   <= BR_NONE;
    end else if (rd_pend_r) begin
      if (rd_near_r) begin
        if (rd_data_r.hazard > near_r) near_r <= rd_data_r.hazard;
      end else if (rd_data_r.hazard > far_r) begin
        far_r <= rd_data_r.hazard;
      end
      if (rd_first_r) begin
        node_hit_r <= rd_data_r.is_node && (rd_data_r.branch != BR_NONE);
        branch_r   <= rd_data_r.branch;
      end
    end
  end

  // speed ramp
  logic signed [11:0] e_x;
  logic [11:0]        mag;
  logic [7:0]         target;
  logic [15:0]        tgt_q;
  logic signed [17:0] spd_w;
  logic [15:0]        spd_nxt;
  logic [15:0]        speed_r;
  logic signed [11:0] prev_r;

  assign e_x = 12'(err_r);
  assign mag = e_x[11] ? 12'(-e_x) : e_x;

  always_comb begin
    priority if (near_r >= HAZ_HIGH) target = SPD_NEAR_HIGH;
    else if (near_r >= HAZ_LOW)      target = SPD_NEAR_LOW;
    else if (far_r >= HAZ_HIGH)      target = SPD_FAR_HIGH;
    else if (far_r >= HAZ_LOW)       target = SPD_FAR_LOW;
    else                             target = top_speed_r;
    priority if (mag > ERR_WIDE) begin
      if (target > SPD_CAP_WIDE) target = SPD_CAP_WIDE;
    end else if (mag > ERR_MID) begin
      if (target > SPD_CAP_MID) target = SPD_CAP_MID;
    end else if (mag > ERR_SLIM) begin
      if (target > SPD_CAP_SLIM) target = SPD_CAP_SLIM;
    end else begin
      target = target;
    end
    tgt_q = {target, 8'd0};
    priority if (speed_r < tgt_q) spd_w = $signed({2'd0, speed_r}) + $signed({6'd0, accel_r});
    else if (speed_r > tgt_q)     spd_w = $signed({2'd0, speed_r}) - $signed({6'd0, decel_r});
    else                          spd_w = $signed({2'd0, speed_r});
    priority if (spd_w < 0)                              spd_nxt = '0;
    else if (spd_w > $signed({2'd0, top_speed_r, 8'd0})) spd_nxt = {top_speed_r, 8'd0};
    else                                                 spd_nxt = spd_w[15:0];
  end

  // shared multiplier for the PD term
  logic [15:0]        mul_a;
  logic signed [11:0] mul_b;
  logic signed [28:0] prod;
  logic signed [29:0] acc_r;

  assign mul_a = (state_r == S_MUL_P) ? gain_p_r : gain_d_r;
  assign mul_b = (state_r == S_MUL_P) ? e_x : (e_x - prev_r);
  assign prod  = 29'($signed({1'b0, mul_a})) * 29'(mul_b);

  always_ff @(posedge clk) begin
    if (state_r == S_MUL_P) begin
      acc_r <= 30'(prod);
    end else if (state_r == S_MUL_D) begin
      acc_r <= acc_r + 30'(prod);
    end
  end

  // steering
  logic signed [29:0] acc_adj;
  logic signed [19:0] pd_o;
  logic signed [19:0] s_w;
  logic signed [13:0] prev3;
  logic signed [13:0] prev3_adj;
  logic signed [19:0] rec_r;
  logic signed [19:0] bias_w;
  logic [7:0]         floor_v;
  logic [7:0]         left_nxt;
  logic [7:0]         right_nxt;
  logic               over_nxt;

  assign acc_adj   = acc_r + (acc_r[29] ? 30'sd4095 : 30'sd0);
  assign pd_o      = 20'(acc_adj >>> 12);
  assign s_w       = $signed({12'd0, speed_r[15:8]});
  assign prev3     = (14'(prev_r) <<< 1) + 14'(prev_r);
  assign prev3_adj = prev3 + (prev3[13] ? 14'sd15 : 14'sd0);
  assign rec_r     = 20'(prev3_adj >>> 4);
  assign bias_w    = $signed({12'd0, BRANCH_BIAS});
  assign floor_v   = (near_r >= HAZ_HIGH || mag > ERR_WIDE) ? 8'd0 : PWM_FLOOR;

  always_comb begin
    over_nxt = 1'b0;
    if (!seen_r) begin
      left_nxt  = clamp_pwm(s_w + rec_r, 8'd0, top_speed_r);
      right_nxt = clamp_pwm(s_w - rec_r, 8'd0, top_speed_r);
    end else if (node_hit_r) begin
      over_nxt = 1'b1;
      unique case (branch_r)
        BR_RIGHT: begin
          left_nxt  = clamp_pwm(s_w + bias_w, 8'd0, top_speed_r);
          right_nxt = clamp_pwm(s_w - bias_w, 8'd0, top_speed_r);
        end
        BR_LEFT: begin
          left_nxt  = clamp_pwm(s_w - bias_w, 8'd0, top_speed_r);
          right_nxt = clamp_pwm(s_w + bias_w, 8'd0, top_speed_r);
        end
        default: begin
          left_nxt  = clamp_pwm(s_w, 8'd0, top_speed_r);
          right_nxt = clamp_pwm(s_w, 8'd0, top_speed_r);
        end
      endcase
    end else begin
      left_nxt  = clamp_pwm(s_w + pd_o, floor_v, top_speed_r);
      right_nxt = clamp_pwm(s_w - pd_o, floor_v, top_speed_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPEED_RST;
      prev_r  <= '0;
    end else if (in_acc && in_cmd == CMD_RESTART) begin
      speed_r <= SPEED_RST;
      prev_r  <= '0;
    end else begin
      if (state_r == S_SPEED) speed_r <= spd_nxt;
      if (out_load && seen_r) prev_r <= e_x;
    end
  end

  // result register
  logic [7:0] left_r;
  logic [7:0] right_r;
  logic       over_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      priority if (out_load)           out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      else                             out_valid_r <= out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      over_r  <= over_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_left_pwm        = left_r;
  assign out_right_pwm       = right_r;
  assign out_branch_override = over_r;

endmodule

`default_nettype wire

[bench/tb_lookahead_speed_steering_control.sv]
`timescale 1ns / 1ps

module tb_lookahead_speed_steering_control;
  import lssc_pkg::*;

  localparam int TRACK_DEPTH   = 256;
  localparam int SCAN_SPAN     = 8;
  localparam int SETTLE_CYCLES = 24;
  localparam int REPORT_LIMIT  = 10;
  localparam int PHASE_ITEMS   = 200;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [7:0] left_pwm;
    logic [7:0] right_pwm;
    logic       branch_override;
  } wheel_cmd_t;

  class wheel_scoreboard;
    entry_t     track[TRACK_DEPTH];
    int         speed_q8;
    int         prev_err;
    int         top_speed, gain_p, gain_d, accel_step, decel_step, map_length;
    wheel_cmd_t wheel_q[$];
    int         errors;

    function new();
      foreach (track[i]) track[i] = '0;
      speed_q8   = SPEED_RST;
      prev_err   = 0;
      top_speed  = TOP_SPEED_RST;
      gain_p     = GAIN_P_RST;
      gain_d     = GAIN_D_RST;
      accel_step = ACCEL_STEP_RST;
      decel_step = DECEL_STEP_RST;
      map_length = MAP_LENGTH_RST;
      errors     = 0;
    endfunction

    function void set_reg(logic [2:0] idx, int unsigned v);
      case (idx)
        REG_TOP_SPEED:  top_speed  = v & 'hFF;
        REG_GAIN_P:     gain_p     = v & 'hFFFF;
        REG_GAIN_D:     gain_d     = v & 'hFFFF;
        REG_ACCEL_STEP: accel_step = v & 'hFFF;
        REG_DECEL_STEP: decel_step = v & 'hFFF;
        REG_MAP_LENGTH: map_length = v & 'h1FF;
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void note_beat(logic [1:0] cmd, logic signed [10:0] line_pos, logic seen,
                            logic [7:0] pos, logic [2:0] haz, logic node, logic [1:0] br);
      int         len, near_h, far_h, target, mag, e, ms, s, flr, bias;
      longint     spd, pd, lft, rgt;
      entry_t     ent;
      wheel_cmd_t res;
      if (cmd == CMD_WRITE) begin
        track[pos] = {br, node, haz};
        return;
      end
      if (cmd == CMD_RESTART) begin
        speed_q8 = SPEED_RST;
        prev_err = 0;
        return;
      end
      if (cmd != CMD_STEP) return;

      e    = line_pos;
      ms   = top_speed;
      bias = BRANCH_BIAS;
      len  = (map_length > TRACK_DEPTH) ? TRACK_DEPTH : map_length;
      near_h = 0;
      far_h  = 0;
      for (int i = 0; i <= SCAN_SPAN; i++) begin
        if (pos + i < len) begin
          if (i <= 2) begin
            if (track[pos + i].hazard > near_h) near_h = track[pos + i].hazard;
          end else if (track[pos + i].hazard > far_h) begin
            far_h = track[pos + i].hazard;
          end
        end
      end

      target = ms;
      if (near_h >= HAZ_HIGH) target = SPD_NEAR_HIGH;
      else if (near_h >= HAZ_LOW) target = SPD_NEAR_LOW;
      else if (far_h >= HAZ_HIGH) target = SPD_FAR_HIGH;
      else if (far_h >= HAZ_LOW) target = SPD_FAR_LOW;

      mag = (e < 0) ? -e : e;
      if (mag > ERR_WIDE) begin
        if (target > SPD_CAP_WIDE) target = SPD_CAP_WIDE;
      end else if (mag > ERR_MID) begin
        if (target > SPD_CAP_MID) target = SPD_CAP_MID;
      end else if (mag > ERR_SLIM) begin
        if (target > SPD_CAP_SLIM) target = SPD_CAP_SLIM;
      end

      spd = speed_q8;
      if (spd < target * 256) spd += accel_step;
      else if (spd > target * 256) spd -= decel_step;
      spd      = clip(spd, 0, ms * 256);
      speed_q8 = int'(spd);
      s        = int'(spd >> 8);

      res.branch_override = 1'b0;
      if (!seen) begin
        pd  = (prev_err * 3) / 16;
        lft = clip(s + pd, 0, ms);
        rgt = clip(s - pd, 0, ms);
      end else begin
        pd = (longint'(gain_p) * e + longint'(gain_d) * (e - prev_err)) / 4096;
        prev_err = e;
        flr = (near_h >= HAZ_HIGH || mag > ERR_WIDE) ? 0 : int'(PWM_FLOOR);
        lft = s + pd;
        rgt = s - pd;
        lft = (lft < flr) ? flr : ((lft > ms) ? ms : lft);
        rgt = (rgt < flr) ? flr : ((rgt > ms) ? ms : rgt);
        if (pos < len) begin
          ent = track[pos];
          if (ent.is_node && ent.branch != BR_NONE) begin
            res.branch_override = 1'b1;
            case (ent.branch)
              BR_RIGHT: begin
                lft = s + bias;
                rgt = s - bias;
              end
              BR_LEFT: begin
                lft = s - bias;
                rgt = s + bias;
              end
              default: begin
                lft = s;
                rgt = s;
              end
            endcase
            lft = clip(lft, 0, ms);
            rgt = clip(rgt, 0, ms);
          end
        end
      end
      res.left_pwm  = lft[7:0];
      res.right_pwm = rgt[7:0];
      wheel_q.push_back(res);
    endfunction

    function void check_wheels(logic [7:0] left_pwm, logic [7:0] right_pwm, logic over);
      wheel_cmd_t want;
      if (wheel_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result beat: left %0d right %0d override %0b",
                   left_pwm, right_pwm, over);
        return;
      end
      want = wheel_q.pop_front();
      if (left_pwm !== want.left_pwm || right_pwm !== want.right_pwm ||
          over !== want.branch_override) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("mismatch: expected left %0d right %0d override %0b, got %0d %0d %0b",
                   want.left_pwm, want.right_pwm, want.branch_override,
                   left_pwm, right_pwm, over);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_cmd = CMD_STEP;
  logic signed [10:0] in_line_position = '0;
  logic               in_line_detected = 1'b0;
  logic [7:0]         in_map_position = '0;
  logic [2:0]         in_entry_hazard = '0;
  logic               in_entry_is_node = 1'b0;
  logic [1:0]         in_entry_branch = BR_NONE;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_left_pwm;
  logic [7:0]         out_right_pwm;
  logic               out_branch_override;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  wheel_scoreboard sb;
  bit              steady_run = 1'b0;
  int              track_pos = 0;

  lookahead_speed_steering_control u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_line_position    (in_line_position),
    .in_line_detected    (in_line_detected),
    .in_map_position     (in_map_position),
    .in_entry_hazard     (in_entry_hazard),
    .in_entry_is_node    (in_entry_is_node),
    .in_entry_branch     (in_entry_branch),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_left_pwm        (out_left_pwm),
    .out_right_pwm       (out_right_pwm),
    .out_branch_override (out_branch_override),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_wheels(out_left_pwm, out_right_pwm, out_branch_override);
    out_stall <= !steady_run && ($urandom_range(0, 99) < 34);
  end

  task automatic send_beat(logic [1:0] cmd, logic signed [10:0] line_pos, logic seen,
                           logic [7:0] pos, logic [2:0] haz, logic node, logic [1:0] br);
    int gap;
    gap = 0;
    while (!steady_run && $urandom_range(0, 99) < 34) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_line_position <= line_pos;
    in_line_detected <= seen;
    in_map_position  <= pos;
    in_entry_hazard  <= haz;
    in_entry_is_node <= node;
    in_entry_branch  <= br;
    do @(posedge clk); while (in_stall);
    sb.note_beat(cmd, line_pos, seen, pos, haz, node, br);
  endtask

  task automatic step_beat(logic signed [10:0] line_pos, logic seen, logic [7:0] pos);
    send_beat(CMD_STEP, line_pos, seen, pos, 3'($urandom), 1'($urandom), 2'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.wheel_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, int unsigned value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_settings(int ms, int gp, int gd, int acc, int dec, int len);
    drain();
    cfg_write(REG_TOP_SPEED, ms);
    cfg_write(REG_GAIN_P, gp);
    cfg_write(REG_GAIN_D, gd);
    cfg_write(REG_ACCEL_STEP, acc);
    cfg_write(REG_DECEL_STEP, dec);
    cfg_write(REG_MAP_LENGTH, len);
  endtask

  function automatic logic signed [10:0] pick_error();
    int mag;
    case ($urandom_range(0, 3))
      0, 1: return 11'($signed($urandom_range(0, 480)) - 240);
      2: begin
        mag = $urandom_range(230, 600);
        return 11'($urandom_range(0, 1) ? -mag : mag);
      end
      default: return 11'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic run_random(int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2 && !steady_run) drain();
      if ($urandom_range(0, 99) < 80) track_pos = (track_pos + $urandom_range(0, 2)) % 256;
      else track_pos = $urandom_range(0, 255);
      roll = $urandom_range(0, 99);
      if (roll < 70)
        step_beat(pick_error(), $urandom_range(0, 99) < 85, 8'(track_pos));
      else if (roll < 85)
        send_beat(CMD_WRITE, pick_error(), 1'($urandom), 8'($urandom), 3'($urandom),
                  1'($urandom), 2'($urandom));
      else if (roll < 92)
        send_beat(CMD_RESTART, pick_error(), 1'($urandom), 8'($urandom), 3'($urandom),
                  1'($urandom), 2'($urandom));
      else if (roll < 96)
        send_beat(CMD_UNUSED, pick_error(), 1'($urandom), 8'($urandom), 3'($urandom),
                  1'($urandom), 2'($urandom));
      else
        step_beat(11'($urandom), 1'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    step_beat(11'sd0, 1'b1, 8'd0);
    step_beat(11'sd1023, 1'b1, 8'd0);
    step_beat(-11'sd1024, 1'b1, 8'd0);
    step_beat(11'sd561, 1'b1, 8'd0);
    step_beat(11'sd560, 1'b1, 8'd0);
    step_beat(11'sd353, 1'b1, 8'd0);
    step_beat(11'sd352, 1'b1, 8'd0);
    step_beat(11'sd241, 1'b1, 8'd0);
    step_beat(11'sd240, 1'b1, 8'd0);
    step_beat(-11'sd561, 1'b1, 8'd0);
    step_beat(11'sd0, 1'b0, 8'd0);
    send_beat(CMD_UNUSED, 11'sd0, 1'b1, 8'd0, 3'd0, 1'b0, BR_NONE);
    send_beat(CMD_RESTART, 11'sd0, 1'b1, 8'd0, 3'd0, 1'b0, BR_NONE);
    step_beat(11'sd0, 1'b0, 8'd0);

    for (int i = 0; i < TRACK_DEPTH; i++)
      send_beat(CMD_WRITE, pick_error(), 1'($urandom), 8'(i), 3'($urandom),
                1'($urandom), 2'($urandom));
    send_beat(CMD_WRITE, 11'sd0, 1'b1, 8'd10, 3'd0, 1'b1, BR_RIGHT);
    send_beat(CMD_WRITE, 11'sd0, 1'b1, 8'd20, 3'd0, 1'b1, BR_LEFT);
    send_beat(CMD_WRITE, 11'sd0, 1'b1, 8'd30, 3'd0, 1'b1, BR_STRAIGHT);
    send_beat(CMD_WRITE, 11'sd0, 1'b1, 8'd40, 3'd7, 1'b1, BR_NONE);
    send_beat(CMD_WRITE, 11'sd0, 1'b1, 8'd60, 3'd4, 1'b0, BR_NONE);

    apply_settings(TOP_SPEED_RST, GAIN_P_RST, GAIN_D_RST, ACCEL_STEP_RST, DECEL_STEP_RST,
                   TRACK_DEPTH);
    step_beat(11'sd16, 1'b1, 8'd10);
    step_beat(-11'sd16, 1'b1, 8'd20);
    step_beat(11'sd0, 1'b1, 8'd30);
    step_beat(11'sd100, 1'b1, 8'd40);
    step_beat(11'sd0, 1'b1, 8'd57);
    step_beat(11'sd0, 1'b0, 8'd10);
    step_beat(11'sd50, 1'b1, 8'd255);

    apply_settings(255, 256, 0, 102, 896, 256);
    run_random(PHASE_ITEMS);
    apply_settings(255, 65535, 65535, 4095, 4095, 511);
    steady_run = 1'b1;
    run_random(PHASE_ITEMS);
    steady_run = 1'b0;
    apply_settings(30, 1024, 512, 300, 600, 100);
    run_random(PHASE_ITEMS);
    apply_settings(0, 0, 0, 0, 0, 1);
    run_random(PHASE_ITEMS);
    apply_settings($urandom_range(0, 255), $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 4095), $urandom_range(0, 4095), 0);
    run_random(PHASE_ITEMS);
    apply_settings($urandom_range(0, 255), $urandom_range(0, 4096), $urandom_range(0, 8192),
                   $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 256));
    run_random(PHASE_ITEMS);

    drain();
    if (sb.errors == 0) begin
      $display("lookahead_speed_steering_control test passed");
    end else begin
      $display("lookahead_speed_steering_control test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("lookahead_speed_steering_control test failed");
    $finish;
  end

endmodule
